>>> design/dcm_gyro_integrator_renormalizer_defines.svh
// Assertion macros used by the attitude integrator controller
`ifndef DCM_GYRO_INTEGRATOR_RENORMALIZER_DEFINES_SVH
`define DCM_GYRO_INTEGRATOR_RENORMALIZER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define DGIR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define DGIR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dgir_pkg.sv
// Types, constants and helpers shared by the attitude integrator modules
package dgir_pkg;

    localparam int MATRIX_FRAC_BITS = 14;
    localparam int RATE_FRAC_BITS   = 10;
    localparam int DT_FRAC_BITS     = 20;
    localparam int INT_SHIFT        = RATE_FRAC_BITS + DT_FRAC_BITS;
    localparam int ORTH_SHIFT       = 2 * MATRIX_FRAC_BITS;
    localparam int NORM_SHIFT       = MATRIX_FRAC_BITS + 8 + 1;

    localparam logic [19:0] SAMPLE_PERIOD_RESET = 20'd1049;
    localparam logic signed [15:0] ELEM_ONE = 16'sd16384;

    // Last count of each sequencer phase
    localparam logic [4:0] INT_LAST   = 5'd4;
    localparam logic [4:0] SQ_LAST    = 5'd4;
    localparam logic [4:0] SQRT_LAST  = 5'd23;
    localparam logic [4:0] DIV_LAST   = 5'd17;
    localparam logic [4:0] DOT_LAST   = 5'd3;
    localparam logic [4:0] ORTH_LAST  = 5'd1;
    localparam logic [4:0] CROSS_LAST = 5'd3;

    typedef logic signed [15:0] elem_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDENT,
        ST_INT,
        ST_COMMIT,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_DOT,
        ST_ORTH,
        ST_CROSS,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_CROSS1,
        MS_CROSS2,
        MS_ACCDT,
        MS_SQ,
        MS_DOT,
        MS_ORTH
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_mode_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_IDENT,
        WR_INT,
        WR_COMMIT,
        WR_NORM,
        WR_ORTH,
        WR_CROSS
    } wr_op_t;

    typedef struct packed {
        mul_sel_t   mul_sel;
        acc_mode_t  acc_mode;
        wr_op_t     wr_op;
        logic [1:0] row;
        logic [1:0] col;
        logic       right_gyro;
        logic       capture;
        logic       sq_start;
        logic       sq_step;
        logic       dv_start;
        logic       dv_step;
        logic       load_out;
    } dgir_cmd_t;

    typedef struct packed {
        logic acc_zero;
    } dgir_stat_t;

    function automatic logic [1:0] next_col(input logic [1:0] c);
        return (c == 2'd2) ? 2'd0 : c + 2'd1;
    endfunction

    function automatic elem_t sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)
            return 16'sh7fff;
        else if (v < -40'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

>>> design/dgir_datapath.sv
// Matrix store, shared multiplier/accumulator, root and divide units
module dgir_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  dgir_pkg::dgir_cmd_t  cmd,
    output dgir_pkg::dgir_stat_t stat,
    input  logic              cfg_we,
    input  logic [19:0]       cfg_wdata,
    input  logic [15:0]       rate_x,
    input  logic [15:0]       rate_y,
    input  logic [15:0]       rate_z,
    output logic [15:0]       elem_00,
    output logic [15:0]       elem_01,
    output logic [15:0]       elem_02,
    output logic [15:0]       elem_10,
    output logic [15:0]       elem_11,
    output logic [15:0]       elem_12,
    output logic [15:0]       elem_20,
    output logic [15:0]       elem_21,
    output logic [15:0]       elem_22
);
    import dgir_pkg::*;

    elem_t m_reg   [3][3];
    elem_t n_reg   [3][3];
    elem_t out_reg [3][3];
    elem_t g_reg   [3];
    logic [19:0] sample_period_reg;

    logic signed [53:0] prod_reg;
    logic signed [33:0] acc_reg;

    logic [47:0] sq_x_reg;
    logic [25:0] sq_rem_reg;
    logic [23:0] sq_root_reg;

    logic [24:0] dv_rem_reg;
    logic [15:0] dv_q_reg;
    logic        dv_neg_reg;

    logic [1:0] c1, c2;
    elem_t lvec [3];
    elem_t rvec [3];
    elem_t cur;
    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [53:0] prod_next;
    logic signed [53:0] int_rnd, orth_rnd;
    logic signed [33:0] cross_rnd;
    logic signed [39:0] int_sum, orth_sum;
    logic [27:0] sq_rem_sh, sq_trial;
    logic        sq_ge;
    logic [15:0] mag;
    logic [38:0] dv_dividend;
    logic [24:0] dv_divisor;
    logic [25:0] dv_r2;
    logic        dv_ge;
    logic signed [15:0] norm_val;

    assign c1  = next_col(cmd.col);
    assign c2  = next_col(c1);
    assign cur = m_reg[cmd.row][cmd.col];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lvec[i] = m_reg[cmd.row][i];
            rvec[i] = cmd.right_gyro ? g_reg[i] : m_reg[1][i];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MS_CROSS1:
            begin
                mul_a = 33'(lvec[c1]);
                mul_b = 21'(rvec[c2]);
            end
            MS_CROSS2:
            begin
                mul_a = 33'(lvec[c2]);
                mul_b = 21'(rvec[c1]);
            end
            MS_ACCDT:
            begin
                mul_a = acc_reg[32:0];
                mul_b = $signed({1'b0, sample_period_reg});
            end
            MS_SQ:
            begin
                mul_a = 33'(cur);
                mul_b = 21'(cur);
            end
            MS_DOT:
            begin
                mul_a = 33'(m_reg[0][cmd.col]);
                mul_b = 21'(m_reg[1][cmd.col]);
            end
            MS_ORTH:
            begin
                mul_a = acc_reg[32:0];
                mul_b = 21'(m_reg[0][cmd.col]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Rounded writebacks
    assign int_rnd   = (prod_reg + (54'sd1 <<< (INT_SHIFT - 1))) >>> INT_SHIFT;
    assign int_sum   = 40'(cur) + $signed(int_rnd[39:0]);
    assign orth_rnd  = (prod_reg + (54'sd1 <<< (ORTH_SHIFT - 1))) >>> ORTH_SHIFT;
    assign orth_sum  = 40'(m_reg[1][cmd.col]) - $signed(orth_rnd[39:0]);
    assign cross_rnd = (acc_reg + (34'sd1 <<< (MATRIX_FRAC_BITS - 1))) >>> MATRIX_FRAC_BITS;

    // Square root, two radicand bits a step
    assign sq_rem_sh = {sq_rem_reg, sq_x_reg[47:46]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge     = sq_rem_sh >= sq_trial;

    // Restoring divide, one quotient bit a step
    assign mag         = cur[15] ? 16'(-cur) : cur;
    assign dv_dividend = {mag, 23'd0} + 39'(sq_root_reg);
    assign dv_divisor  = {sq_root_reg, 1'b0};
    assign dv_r2       = {dv_rem_reg, dv_q_reg[15]};
    assign dv_ge       = dv_r2 >= {1'b0, dv_divisor};
    assign norm_val    = dv_neg_reg ? -$signed(dv_q_reg) : $signed(dv_q_reg);

    assign stat.acc_zero = (acc_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SAMPLE_PERIOD_RESET;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    m_reg[r][c] <= (r == c) ? ELEM_ONE : '0;
        end
        else
        begin
            if (cfg_we)
                sample_period_reg <= cfg_wdata;
            case (cmd.wr_op)
                WR_IDENT:
                    for (int r = 0; r < 3; r++)
                        for (int c = 0; c < 3; c++)
                            m_reg[r][c] <= (r == c) ? ELEM_ONE : '0;
                WR_COMMIT:
                    m_reg <= n_reg;
                WR_NORM:
                    m_reg[cmd.row][cmd.col] <= norm_val;
                WR_ORTH:
                    m_reg[1][cmd.col] <= sat16(orth_sum);
                WR_CROSS:
                    m_reg[2][cmd.col] <= sat16(40'(cross_rnd));
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd.acc_mode)
            ACC_LOAD: acc_reg <= prod_reg[33:0];
            ACC_ADD:  acc_reg <= acc_reg + $signed(prod_reg[33:0]);
            ACC_SUB:  acc_reg <= acc_reg - $signed(prod_reg[33:0]);
            default:  acc_reg <= acc_reg;
        endcase
        if (cmd.capture)
        begin
            g_reg[0] <= rate_x;
            g_reg[1] <= rate_y;
            g_reg[2] <= rate_z;
        end
        if (cmd.wr_op == WR_INT)
            n_reg[cmd.row][cmd.col] <= sat16(int_sum);
        if (cmd.sq_start)
        begin
            sq_x_reg    <= {acc_reg[31:0], 16'd0};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_x_reg    <= {sq_x_reg[45:0], 2'b00};
            sq_rem_reg  <= sq_ge ? 26'(sq_rem_sh - sq_trial) : sq_rem_sh[25:0];
            sq_root_reg <= {sq_root_reg[22:0], sq_ge};
        end
        if (cmd.dv_start)
        begin
            dv_rem_reg <= 25'(dv_dividend[38:16]);
            dv_q_reg   <= dv_dividend[15:0];
            dv_neg_reg <= cur[15];
        end
        else if (cmd.dv_step)
        begin
            dv_rem_reg <= dv_ge ? 25'(dv_r2 - {1'b0, dv_divisor}) : dv_r2[24:0];
            dv_q_reg   <= {dv_q_reg[14:0], dv_ge};
        end
        if (cmd.load_out)
            out_reg <= m_reg;
    end

    assign elem_00 = out_reg[0][0];
    assign elem_01 = out_reg[0][1];
    assign elem_02 = out_reg[0][2];
    assign elem_10 = out_reg[1][0];
    assign elem_11 = out_reg[1][1];
    assign elem_12 = out_reg[1][2];
    assign elem_20 = out_reg[2][0];
    assign elem_21 = out_reg[2][1];
    assign elem_22 = out_reg[2][2];

endmodule

>>> design/dgir_ctrl.sv
// Sequencer that steps the datapath through integration and renormalization
`include "dcm_gyro_integrator_renormalizer_defines.svh"

module dgir_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 renormalize,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  dgir_pkg::dgir_stat_t stat,
    output dgir_pkg::dgir_cmd_t  cmd
);
    import dgir_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       renorm_reg, renorm_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            renorm_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            renorm_reg    <= renorm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and sequencing counters
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg + 5'd1;
        row_next    = row_reg;
        col_next    = col_reg;
        renorm_next = renorm_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                row_next = '0;
                col_next = '0;
                if (in_valid)
                begin
                    renorm_next = renormalize;
                    state_next  = restart ? ST_IDENT : ST_INT;
                end
            end
            ST_IDENT:
                state_next = ST_FIN;
            ST_INT:
                if (cnt_reg == INT_LAST)
                begin
                    cnt_next = '0;
                    if (col_reg == 2'd2)
                    begin
                        col_next = '0;
                        if (row_reg == 2'd2)
                            state_next = ST_COMMIT;
                        else
                            row_next = row_reg + 2'd1;
                    end
                    else
                        col_next = col_reg + 2'd1;
                end
            ST_COMMIT:
            begin
                cnt_next   = '0;
                row_next   = '0;
                state_next = renorm_reg ? ST_SQ : ST_FIN;
            end
            ST_SQ:
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next = '0;
                    col_next = '0;
                    // zero-length row stays as it is
                    if (!stat.acc_zero)
                        state_next = ST_SQRT;
                    else
                        state_next = (row_reg == 2'd0) ? ST_DOT : ST_CROSS;
                end
            ST_SQRT:
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            ST_DIV:
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    if (col_reg == 2'd2)
                    begin
                        col_next   = '0;
                        state_next = (row_reg == 2'd0) ? ST_DOT : ST_CROSS;
                    end
                    else
                        col_next = col_reg + 2'd1;
                end
            ST_DOT:
                if (cnt_reg == DOT_LAST)
                begin
                    cnt_next   = '0;
                    col_next   = '0;
                    state_next = ST_ORTH;
                end
            ST_ORTH:
                if (cnt_reg == ORTH_LAST)
                begin
                    cnt_next = '0;
                    if (col_reg == 2'd2)
                    begin
                        col_next   = '0;
                        row_next   = 2'd1;
                        state_next = ST_SQ;
                    end
                    else
                        col_next = col_reg + 2'd1;
                end
            ST_CROSS:
                if (cnt_reg == CROSS_LAST)
                begin
                    cnt_next = '0;
                    if (col_reg == 2'd2)
                        state_next = ST_FIN;
                    else
                        col_next = col_reg + 2'd1;
                end
            ST_FIN:
            begin
                // keep the counter cleared and wait while the output slot is busy
                cnt_next = '0;
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MS_NONE;
        cmd.acc_mode   = ACC_HOLD;
        cmd.wr_op      = WR_NONE;
        cmd.row        = row_reg;
        cmd.col        = col_reg;
        in_ready       = 1'b0;
        out_valid_next = (out_valid_reg && !out_ready);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_IDENT:
                cmd.wr_op = WR_IDENT;
            ST_INT:
            begin
                cmd.right_gyro = 1'b1;
                case (cnt_reg)
                    5'd0: cmd.mul_sel = MS_CROSS1;
                    5'd1:
                    begin
                        cmd.mul_sel  = MS_CROSS2;
                        cmd.acc_mode = ACC_LOAD;
                    end
                    5'd2: cmd.acc_mode = ACC_SUB;
                    5'd3: cmd.mul_sel  = MS_ACCDT;
                    default: cmd.wr_op = WR_INT;
                endcase
            end
            ST_COMMIT:
                cmd.wr_op = WR_COMMIT;
            ST_SQ:
            begin
                cmd.col = (cnt_reg <= 5'd2) ? cnt_reg[1:0] : 2'd0;
                if (cnt_reg <= 5'd2)
                    cmd.mul_sel = MS_SQ;
                if (cnt_reg == 5'd1)
                    cmd.acc_mode = ACC_LOAD;
                else if (cnt_reg inside {5'd2, 5'd3})
                    cmd.acc_mode = ACC_ADD;
                cmd.sq_start = (cnt_reg == SQ_LAST);
            end
            ST_SQRT:
                cmd.sq_step = 1'b1;
            ST_DIV:
            begin
                cmd.dv_start = (cnt_reg == 5'd0);
                cmd.dv_step  = (cnt_reg != 5'd0) && (cnt_reg != DIV_LAST);
                if (cnt_reg == DIV_LAST)
                    cmd.wr_op = WR_NORM;
            end
            ST_DOT:
            begin
                cmd.col = (cnt_reg == DOT_LAST) ? 2'd0 : cnt_reg[1:0];
                if (cnt_reg <= 5'd2)
                    cmd.mul_sel = MS_DOT;
                if (cnt_reg == 5'd1)
                    cmd.acc_mode = ACC_LOAD;
                else if (cnt_reg inside {5'd2, 5'd3})
                    cmd.acc_mode = ACC_ADD;
            end
            ST_ORTH:
                if (cnt_reg == 5'd0)
                    cmd.mul_sel = MS_ORTH;
                else
                    cmd.wr_op = WR_ORTH;
            ST_CROSS:
            begin
                cmd.row = 2'd0;
                case (cnt_reg)
                    5'd0: cmd.mul_sel = MS_CROSS1;
                    5'd1:
                    begin
                        cmd.mul_sel  = MS_CROSS2;
                        cmd.acc_mode = ACC_LOAD;
                    end
                    5'd2: cmd.acc_mode = ACC_SUB;
                    default: cmd.wr_op = WR_CROSS;
                endcase
            end
            ST_FIN:
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            default:
                ;
        endcase
    end

    assign out_valid = out_valid_reg;

    `DGIR_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != ST_IDLE, "accepted word did not start work")
    `DGIR_ASSERT_NXT(a_fin_presents, state_reg == ST_FIN && slot_free, out_valid_reg, "finished matrix not presented")
    `DGIR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= SQRT_LAST, "step counter out of range")
    `DGIR_ASSERT_IMP(a_row_bound, 1'b1, row_reg != 2'd3, "row index out of range")

endmodule

>>> design/dcm_gyro_integrator_renormalizer.sv
// Top level: direction cosine matrix integrator with Gram-Schmidt renormalization
// A new word is accepted only while idle, so it waits until the previous word is done
// and its matrix has been loaded into the output register, which waits while out_valid
// is held without out_ready. The work is serialized on the shared multiplier, the
// 24-step root and the 16-step divide.
// Reset (rst_n, async low): matrix to identity, sample period to 1049, output empty.
module dcm_gyro_integrator_renormalizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] rate_x,
    input  logic [15:0] rate_y,
    input  logic [15:0] rate_z,
    input  logic        renormalize,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] elem_00,
    output logic [15:0] elem_01,
    output logic [15:0] elem_02,
    output logic [15:0] elem_10,
    output logic [15:0] elem_11,
    output logic [15:0] elem_12,
    output logic [15:0] elem_20,
    output logic [15:0] elem_21,
    output logic [15:0] elem_22
);
    import dgir_pkg::*;

    // Controller sequences each word: integrate all nine entries into a shadow
    // matrix, commit, then optionally normalize row 0, orthogonalize and
    // normalize row 1, and rebuild row 2 as the cross product (restart loads identity).
    dgir_cmd_t  cmd;
    dgir_stat_t stat;

    dgir_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .renormalize (renormalize),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Datapath holds the matrix, the multiply-accumulate pipe and the
    // iterative root and divide units; the output register is loaded on finish.
    dgir_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rate_x    (rate_x),
        .rate_y    (rate_y),
        .rate_z    (rate_z),
        .elem_00   (elem_00),
        .elem_01   (elem_01),
        .elem_02   (elem_02),
        .elem_10   (elem_10),
        .elem_11   (elem_11),
        .elem_12   (elem_12),
        .elem_20   (elem_20),
        .elem_21   (elem_21),
        .elem_22   (elem_22)
    );

endmodule
